>>> design/adrl_pkg.sv
// ---------------------------------------------------------------------------
// adrl_pkg: shared types and constants of the address-to-DIMM range lookup
// Holds the range entry format, the table write request and the load-time
// range forming function.
// ---------------------------------------------------------------------------
`default_nettype none

package adrl_pkg;

    localparam int SLOT_W   = 6;
    localparam int ADDR_W   = 64;
    localparam int KB_W     = 32;
    localparam int LEN_W    = 8;
    localparam int HANDLE_W = 16;
    localparam int COUNT_W  = 7;
    localparam int MAX_SCAN = 64;

    localparam logic [LEN_W-1:0] EXT_MIN_LENGTH = 8'h23;
    localparam logic [KB_W-1:0]  KB_ALL_ONES    = 32'hFFFF_FFFF;
    localparam logic [9:0]       KB_TAIL        = 10'h3FF;

    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   range_start;
        logic [ADDR_W-1:0]   range_end;
        logic [HANDLE_W-1:0] device;
        logic                present;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        entry_t            entry;
    } wr_req_t;

    function automatic entry_t form_entry(
        input logic [KB_W-1:0]     start_kb,
        input logic [KB_W-1:0]     end_kb,
        input logic [ADDR_W-1:0]   start_wide,
        input logic [ADDR_W-1:0]   end_wide,
        input logic [LEN_W-1:0]    record_length,
        input logic [HANDLE_W-1:0] handle,
        input logic                present
    );
        entry_t e;
        e.device  = handle;
        e.present = present;
        if ((record_length >= EXT_MIN_LENGTH) && (start_kb == KB_ALL_ONES))
        begin
            e.range_start = start_wide;
            e.range_end   = end_wide;
        end
        else
        begin
            e.range_start = {22'd0, start_kb, 10'd0};
            e.range_end   = {22'd0, end_kb, KB_TAIL};
        end
        return e;
    endfunction

endpackage

`default_nettype wire

>>> design/adrl_table.sv
// ---------------------------------------------------------------------------
// adrl_table: range record memory
// One-write, one-read synchronous memory of range entries with a registered
// read, plus per-slot valid bits cleared by reset.
// ---------------------------------------------------------------------------
`default_nettype none

module adrl_table #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire adrl_pkg::wr_req_t wr,
    input  wire logic [IDX_W-1:0] rd_idx,
    output adrl_pkg::entry_t      rd_entry_reg,
    output logic                  rd_valid_reg
);

    adrl_pkg::entry_t mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.slot[IDX_W-1:0]] <= wr.entry;
        end
        rd_entry_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.slot[IDX_W-1:0]] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

endmodule

`default_nettype wire

>>> design/adrl_ctrl.sv
// ---------------------------------------------------------------------------
// adrl_ctrl: transaction control and slot scan
// Accepts load and lookup transactions, issues table writes, walks the table
// one slot per cycle for a lookup and holds the result in an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module adrl_ctrl #(
    parameter int RANGE_SLOTS = 64,
    parameter int SCAN_SLOTS  = 64,
    parameter int IDX_W       = 6
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            opcode,
    input  wire logic [adrl_pkg::SLOT_W-1:0]     slot,
    input  wire logic [adrl_pkg::KB_W-1:0]       start_kb,
    input  wire logic [adrl_pkg::KB_W-1:0]       end_kb,
    input  wire logic [adrl_pkg::ADDR_W-1:0]     start_bytes_wide,
    input  wire logic [adrl_pkg::ADDR_W-1:0]     end_bytes_wide,
    input  wire logic [adrl_pkg::LEN_W-1:0]      record_length,
    input  wire logic [adrl_pkg::HANDLE_W-1:0]   device_handle,
    input  wire logic                            device_present,
    input  wire logic [adrl_pkg::ADDR_W-1:0]     query_address,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 found,
    output logic [adrl_pkg::HANDLE_W-1:0]        hit_handle,
    output logic [adrl_pkg::SLOT_W-1:0]          hit_slot,
    output logic [adrl_pkg::COUNT_W-1:0]         match_count,
    output adrl_pkg::wr_req_t                    wr,
    output logic [IDX_W-1:0]                     rd_idx,
    input  wire adrl_pkg::entry_t                rd_entry,
    input  wire logic                            rd_valid
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN_SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t                             state_reg;
    logic [IDX_W-1:0]                   idx_reg;
    logic                               pipe_reg;
    logic [IDX_W-1:0]                   pipe_idx_reg;
    logic [adrl_pkg::ADDR_W-1:0]        addr_reg;
    logic                               hit_reg;
    logic [adrl_pkg::HANDLE_W-1:0]      handle_reg;
    logic [adrl_pkg::SLOT_W-1:0]        slot_reg;
    logic [adrl_pkg::COUNT_W-1:0]       count_reg;
    logic                               out_valid_reg;
    logic                               found_reg;
    logic [adrl_pkg::HANDLE_W-1:0]      hit_handle_reg;
    logic [adrl_pkg::SLOT_W-1:0]        hit_slot_reg;
    logic [adrl_pkg::COUNT_W-1:0]       match_count_reg;

    logic accept;
    logic is_lookup;
    logic slot_in_range;
    logic match;

    assign in_ready      = (state_reg == S_IDLE);
    assign accept        = in_valid && in_ready;
    assign is_lookup     = (opcode == adrl_pkg::OP_LOOKUP);
    assign slot_in_range = (32'(slot) < 32'(RANGE_SLOTS));

    assign wr.en    = accept && !is_lookup && slot_in_range;
    assign wr.slot  = slot;
    assign wr.entry = adrl_pkg::form_entry(start_kb, end_kb, start_bytes_wide,
                                           end_bytes_wide, record_length,
                                           device_handle, device_present);

    assign rd_idx = idx_reg;

    assign match = pipe_reg && rd_valid && rd_entry.present
                   && (addr_reg >= rd_entry.range_start)
                   && (addr_reg <= rd_entry.range_end);

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign hit_handle  = hit_handle_reg;
    assign hit_slot    = hit_slot_reg;
    assign match_count = match_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            pipe_reg        <= 1'b0;
            pipe_idx_reg    <= '0;
            addr_reg        <= '0;
            hit_reg         <= 1'b0;
            handle_reg      <= '0;
            slot_reg        <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
            found_reg       <= 1'b0;
            hit_handle_reg  <= '0;
            hit_slot_reg    <= '0;
            match_count_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            pipe_reg     <= (state_reg == S_SCAN);
            pipe_idx_reg <= idx_reg;

            if (match)
            begin
                if (!hit_reg)
                begin
                    hit_reg    <= 1'b1;
                    handle_reg <= rd_entry.device;
                    slot_reg   <= adrl_pkg::SLOT_W'(pipe_idx_reg);
                end
                count_reg <= count_reg + 1'b1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept && is_lookup)
                    begin
                        addr_reg   <= query_address;
                        idx_reg    <= '0;
                        hit_reg    <= 1'b0;
                        handle_reg <= '0;
                        slot_reg   <= '0;
                        count_reg  <= '0;
                        state_reg  <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        found_reg       <= hit_reg;
                        hit_handle_reg  <= handle_reg;
                        hit_slot_reg    <= slot_reg;
                        match_count_reg <= count_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/address_to_dimm_range_lookup.sv
// ---------------------------------------------------------------------------
// address_to_dimm_range_lookup: physical address to memory device lookup
// Stores memory range records in a table and finds the first present device
// whose inclusive byte range holds a queried address.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   opcode, slot, range fields, query
// out      output     out_valid / out_ready found, hit_handle, hit_slot, count
//
// A load transaction is written to the table as it is accepted. A lookup
// scans min(RANGE_SLOTS, 64) slots, paced by the single table read port that
// delivers one slot per cycle. Reset clears the slot valid bits at once and
// needs no clearing pass. While a result waits in the output register a new
// transaction is accepted; a finished scan holds until that register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module address_to_dimm_range_lookup #(
    parameter int RANGE_SLOTS = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            opcode,
    input  wire logic [adrl_pkg::SLOT_W-1:0]     slot,
    input  wire logic [adrl_pkg::KB_W-1:0]       start_kb,
    input  wire logic [adrl_pkg::KB_W-1:0]       end_kb,
    input  wire logic [adrl_pkg::ADDR_W-1:0]     start_bytes_wide,
    input  wire logic [adrl_pkg::ADDR_W-1:0]     end_bytes_wide,
    input  wire logic [adrl_pkg::LEN_W-1:0]      record_length,
    input  wire logic [adrl_pkg::HANDLE_W-1:0]   device_handle,
    input  wire logic                            device_present,
    input  wire logic [adrl_pkg::ADDR_W-1:0]     query_address,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 found,
    output logic [adrl_pkg::HANDLE_W-1:0]        hit_handle,
    output logic [adrl_pkg::SLOT_W-1:0]          hit_slot,
    output logic [adrl_pkg::COUNT_W-1:0]         match_count
);

    // Only the first 64 slots are reachable by the slot field.
    localparam int SCAN_SLOTS = (RANGE_SLOTS < adrl_pkg::MAX_SCAN) ?
                                RANGE_SLOTS : adrl_pkg::MAX_SCAN;
    localparam int IDX_W      = (SCAN_SLOTS > 1) ? $clog2(SCAN_SLOTS) : 1;

    adrl_pkg::wr_req_t wr;
    adrl_pkg::entry_t  rd_entry;
    logic [IDX_W-1:0]  rd_idx;
    logic              rd_valid;

    adrl_table #(
        .DEPTH (SCAN_SLOTS),
        .IDX_W (IDX_W)
    ) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (wr),
        .rd_idx       (rd_idx),
        .rd_entry_reg (rd_entry),
        .rd_valid_reg (rd_valid)
    );

    adrl_ctrl #(
        .RANGE_SLOTS (RANGE_SLOTS),
        .SCAN_SLOTS  (SCAN_SLOTS),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .slot             (slot),
        .start_kb         (start_kb),
        .end_kb           (end_kb),
        .start_bytes_wide (start_bytes_wide),
        .end_bytes_wide   (end_bytes_wide),
        .record_length    (record_length),
        .device_handle    (device_handle),
        .device_present   (device_present),
        .query_address    (query_address),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .found            (found),
        .hit_handle       (hit_handle),
        .hit_slot         (hit_slot),
        .match_count      (match_count),
        .wr               (wr),
        .rd_idx           (rd_idx),
        .rd_entry         (rd_entry),
        .rd_valid         (rd_valid)
    );

endmodule

`default_nettype wire

>>> design/adrl_chk.sv
// ---------------------------------------------------------------------------
// adrl_chk: port-level checks for the range lookup
// Watches the top-level ports and is bound to every instance of the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module adrl_chk (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_ready,
    input wire logic                            opcode,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic                            found,
    input wire logic [adrl_pkg::HANDLE_W-1:0]   hit_handle,
    input wire logic [adrl_pkg::SLOT_W-1:0]     hit_slot,
    input wire logic [adrl_pkg::COUNT_W-1:0]    match_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found)
            && $stable(hit_handle) && $stable(hit_slot) && $stable(match_count))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> hit_handle == '0 && hit_slot == '0
            && match_count == '0)
        else $error("miss result carries nonzero fields");

    a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> match_count != '0)
        else $error("hit reported with zero match count");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> match_count <= 7'(adrl_pkg::MAX_SCAN))
        else $error("match count exceeds table size");

    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == adrl_pkg::OP_LOOKUP |=> !in_ready)
        else $error("transaction accepted during a lookup scan");

endmodule

bind address_to_dimm_range_lookup adrl_chk u_adrl_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .hit_handle  (hit_handle),
    .hit_slot    (hit_slot),
    .match_count (match_count)
);

`default_nettype wire

>>> tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench: address-to-memory-device range lookup
// Loads range records into the table and looks up addresses. A short directed
// table covers table edges, wide and kilobyte fields, absent devices, inverted
// ranges and reloads. A random part follows, including a full-table overlap phase.
// Every lookup result is checked against the directed table's value or a scoreboard
// model of the table, under random idle and stall bursts on both channels.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import adrl_pkg::*;

    localparam int NUM_SLOTS    = 64;
    localparam int RANDOM_ITEMS = 1280;
    localparam int FILL_AT      = 640;
    localparam int CALM_TAIL    = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 80;
    localparam int COMPACT_TOP  = 1 << 22;
    localparam logic [ADDR_W-1:0] ADDR_ONES = '1;

    typedef struct {
        op_t                 op;
        logic [SLOT_W-1:0]   slot;
        logic [KB_W-1:0]     start_kb;
        logic [KB_W-1:0]     end_kb;
        logic [ADDR_W-1:0]   start_wide;
        logic [ADDR_W-1:0]   end_wide;
        logic [LEN_W-1:0]    rec_len;
        logic [HANDLE_W-1:0] handle;
        logic                present;
        logic [ADDR_W-1:0]   query;
    } txn_t;

    typedef struct packed {
        logic                found;
        logic [HANDLE_W-1:0] handle;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  count;
    } hit_t;

    typedef struct {
        txn_t txn;
        bit   typed;
        hit_t want;
    } directed_row_t;

    logic                clk;
    logic                rst_n            = 1'b0;
    logic                in_valid         = 1'b0;
    logic                in_ready;
    logic                opcode           = 1'b0;
    logic [SLOT_W-1:0]   slot             = '0;
    logic [KB_W-1:0]     start_kb         = '0;
    logic [KB_W-1:0]     end_kb           = '0;
    logic [ADDR_W-1:0]   start_bytes_wide = '0;
    logic [ADDR_W-1:0]   end_bytes_wide   = '0;
    logic [LEN_W-1:0]    record_length    = '0;
    logic [HANDLE_W-1:0] device_handle    = '0;
    logic                device_present   = 1'b0;
    logic [ADDR_W-1:0]   query_address    = '0;
    logic                out_valid;
    logic                out_ready        = 1'b0;
    logic                found;
    logic [HANDLE_W-1:0] hit_handle;
    logic [SLOT_W-1:0]   hit_slot;
    logic [COUNT_W-1:0]  match_count;

    logic [ADDR_W-1:0]   tbl_lo      [NUM_SLOTS];
    logic [ADDR_W-1:0]   tbl_hi      [NUM_SLOTS];
    logic [HANDLE_W-1:0] tbl_dev     [NUM_SLOTS];
    bit                  tbl_present [NUM_SLOTS];
    bit                  tbl_valid   [NUM_SLOTS];

    hit_t pending_hits[$];
    int   error_count   = 0;
    int   n_loads       = 0;
    int   n_lookups     = 0;
    int   n_hits        = 0;
    int   max_count     = 0;
    int   idle_cycles   = 0;
    int   in_gap_pct    = 20;
    int   out_stall_pct = 20;

    address_to_dimm_range_lookup #(
        .RANGE_SLOTS(NUM_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .slot(slot),
        .start_kb(start_kb),
        .end_kb(end_kb),
        .start_bytes_wide(start_bytes_wide),
        .end_bytes_wide(end_bytes_wide),
        .record_length(record_length),
        .device_handle(device_handle),
        .device_present(device_present),
        .query_address(query_address),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .found(found),
        .hit_handle(hit_handle),
        .hit_slot(hit_slot),
        .match_count(match_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 50;
        endcase
    endfunction

    function automatic void table_load(input txn_t t);
        if ((t.rec_len >= EXT_MIN_LENGTH) && (t.start_kb == KB_ALL_ONES))
        begin
            tbl_lo[t.slot] = t.start_wide;
            tbl_hi[t.slot] = t.end_wide;
        end
        else
        begin
            tbl_lo[t.slot] = ADDR_W'(t.start_kb) << 10;
            tbl_hi[t.slot] = (ADDR_W'(t.end_kb) << 10) | ADDR_W'(KB_TAIL);
        end
        tbl_dev[t.slot]     = t.handle;
        tbl_present[t.slot] = t.present;
        tbl_valid[t.slot]   = 1'b1;
    endfunction

    function automatic hit_t table_search(input logic [ADDR_W-1:0] addr);
        hit_t r;
        int   n;
        r = '0;
        n = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (tbl_valid[i] && tbl_present[i] && addr >= tbl_lo[i] && addr <= tbl_hi[i])
            begin
                if (!r.found)
                begin
                    r.found  = 1'b1;
                    r.handle = tbl_dev[i];
                    r.slot   = SLOT_W'(i);
                end
                n++;
            end
        end
        r.count = COUNT_W'(n);
        return r;
    endfunction

    function automatic txn_t random_fields();
        txn_t t;
        t.op         = OP_LOAD;
        t.slot       = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        t.start_kb   = $urandom;
        t.end_kb     = $urandom;
        t.start_wide = rand64();
        t.end_wide   = rand64();
        t.rec_len    = LEN_W'($urandom_range(0, 255));
        t.handle     = HANDLE_W'($urandom);
        t.present    = ($urandom_range(0, 99) < 85);
        t.query      = rand64();
        return t;
    endfunction

    function automatic txn_t random_load(input logic [SLOT_W-1:0] s);
        txn_t              t;
        logic [ADDR_W-1:0] span;
        t    = random_fields();
        t.slot = s;
        span = ADDR_W'($urandom_range(0, COMPACT_TOP));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                t.start_kb = KB_W'($urandom_range(0, 4095));
                t.end_kb   = t.start_kb + KB_W'($urandom_range(0, 512));
            end
            5: ;
            6, 7:
            begin
                t.start_kb   = KB_ALL_ONES;
                t.rec_len    = LEN_W'($urandom_range(EXT_MIN_LENGTH, 255));
                t.start_wide = $urandom_range(0, 1) ? ADDR_W'($urandom_range(0, COMPACT_TOP))
                                                    : rand64();
                t.end_wide   = t.start_wide + span;
            end
            8:
            begin
                t.start_kb = KB_ALL_ONES;
                t.rec_len  = LEN_W'($urandom_range(EXT_MIN_LENGTH, 255));
                t.end_wide = t.start_wide - span - 1;
            end
            default:
            begin
                t.start_kb = KB_ALL_ONES;
                t.rec_len  = LEN_W'($urandom_range(0, EXT_MIN_LENGTH - 1));
            end
        endcase
        return t;
    endfunction

    function automatic txn_t random_lookup();
        txn_t              t;
        int                pick;
        int                s;
        logic [ADDR_W-1:0] span;
        t    = random_fields();
        t.op = OP_LOOKUP;
        pick = $urandom_range(0, 9);
        s    = $urandom_range(0, NUM_SLOTS - 1);
        if (pick < 6 && tbl_valid[s])
        begin
            case ($urandom_range(0, 4))
                0: t.query = tbl_lo[s];
                1: t.query = tbl_hi[s];
                2: t.query = tbl_lo[s] - 1;
                3: t.query = tbl_hi[s] + 1;
                default:
                begin
                    span    = tbl_hi[s] - tbl_lo[s];
                    t.query = (span == ADDR_ONES) ? rand64() : tbl_lo[s] + rand64() % (span + 1);
                end
            endcase
        end
        else if (pick < 8)
        begin
            t.query = ADDR_W'($urandom_range(0, COMPACT_TOP));
        end
        return t;
    endfunction

    function automatic directed_row_t load_row(
        input logic [SLOT_W-1:0]   s,
        input logic [KB_W-1:0]     skb,
        input logic [KB_W-1:0]     ekb,
        input logic [ADDR_W-1:0]   sw,
        input logic [ADDR_W-1:0]   ew,
        input logic [LEN_W-1:0]    len,
        input logic [HANDLE_W-1:0] h,
        input logic                p
    );
        directed_row_t r;
        r.txn            = random_fields();
        r.txn.slot       = s;
        r.txn.start_kb   = skb;
        r.txn.end_kb     = ekb;
        r.txn.start_wide = sw;
        r.txn.end_wide   = ew;
        r.txn.rec_len    = len;
        r.txn.handle     = h;
        r.txn.present    = p;
        r.typed          = 1'b0;
        r.want           = '0;
        return r;
    endfunction

    function automatic directed_row_t query_row(
        input logic [ADDR_W-1:0] addr,
        input bit                typed,
        input hit_t              want
    );
        directed_row_t r;
        r.txn       = random_fields();
        r.txn.op    = OP_LOOKUP;
        r.txn.query = addr;
        r.typed     = typed;
        r.want      = want;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 50)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic issue(input txn_t t, input bit typed, input hit_t want);
        if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid         <= 1'b1;
        opcode           <= t.op;
        slot             <= t.slot;
        start_kb         <= t.start_kb;
        end_kb           <= t.end_kb;
        start_bytes_wide <= t.start_wide;
        end_bytes_wide   <= t.end_wide;
        record_length    <= t.rec_len;
        device_handle    <= t.handle;
        device_present   <= t.present;
        query_address    <= t.query;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (t.op == OP_LOAD)
        begin
            table_load(t);
            n_loads++;
        end
        else
        begin
            pending_hits.push_back(typed ? want : table_search(t.query));
            n_lookups++;
        end
    endtask

    initial
    begin
        while (!rst_n) @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        hit_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_hits.size() == 0)
            begin
                report_mismatch("result with no lookup outstanding");
            end
            else
            begin
                want = pending_hits.pop_front();
                if (found !== want.found)
                    report_mismatch($sformatf("found %b, expected %b", found, want.found));
                if (hit_handle !== want.handle)
                    report_mismatch($sformatf("hit_handle %h, expected %h",
                                              hit_handle, want.handle));
                if (hit_slot !== want.slot)
                    report_mismatch($sformatf("hit_slot %0d, expected %0d",
                                              hit_slot, want.slot));
                if (match_count !== want.count)
                    report_mismatch($sformatf("match_count %0d, expected %0d",
                                              match_count, want.count));
                if (want.found)
                    n_hits++;
                if (int'(want.count) > max_count)
                    max_count = int'(want.count);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no transaction for %0d cycles", $time, idle_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        directed_row_t rows[$];
        txn_t          t;
        hit_t          none;
        none = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(query_row('0, 1'b1, none));
        rows.push_back(query_row(ADDR_ONES, 1'b1, none));
        rows.push_back(load_row(6'd0, '0, '0, '0, '0, 8'h10, 16'hAAAA, 1'b1));
        rows.push_back(query_row(64'h3FF, 1'b1, '{1'b1, 16'hAAAA, 6'd0, 7'd1}));
        rows.push_back(query_row(64'h400, 1'b1, none));
        rows.push_back(load_row(6'd63, KB_ALL_ONES, '0, 64'hFFFF_FFFF_FFFF_F000, ADDR_ONES,
                                EXT_MIN_LENGTH, 16'h5555, 1'b1));
        rows.push_back(query_row(ADDR_ONES, 1'b1, '{1'b1, 16'h5555, 6'd63, 7'd1}));
        rows.push_back(load_row(6'd1, KB_ALL_ONES, KB_ALL_ONES, ADDR_ONES, '0,
                                EXT_MIN_LENGTH - 1, 16'hFFFF, 1'b1));
        rows.push_back(query_row(64'h3FF_FFFF_FFFF, 1'b1, '{1'b1, 16'hFFFF, 6'd1, 7'd1}));
        rows.push_back(query_row(64'h3FF_FFFF_FBFF, 1'b0, none));
        rows.push_back(load_row(6'd2, '0, KB_ALL_ONES, '0, '0, 8'hFF, 16'h1234, 1'b0));
        rows.push_back(query_row(64'h100, 1'b1, '{1'b1, 16'hAAAA, 6'd0, 7'd1}));
        rows.push_back(load_row(6'd3, KB_ALL_ONES, '0, 64'h2000, 64'h1FFF, 8'hFF,
                                16'h0001, 1'b1));
        rows.push_back(query_row(64'h1FFF, 1'b0, none));
        rows.push_back(query_row(64'h2000, 1'b0, none));
        rows.push_back(load_row(6'd2, '0, KB_ALL_ONES, '0, '0, 8'h00, 16'h0002, 1'b1));
        rows.push_back(query_row(64'h100, 1'b0, none));
        rows.push_back(load_row(6'd62, KB_ALL_ONES, '0, '0, ADDR_ONES, 8'hFF, 16'hBEEF, 1'b1));
        rows.push_back(query_row(ADDR_ONES, 1'b0, none));
        rows.push_back(query_row('0, 1'b0, none));
        rows.push_back(load_row(6'd0, '0, '0, '0, '0, 8'h23, 16'h0000, 1'b1));
        rows.push_back(query_row(64'h3FF, 1'b0, none));

        foreach (rows[k])
            issue(rows[k].txn, rows[k].typed, rows[k].want);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
            begin
                in_gap_pct    = pick_pct();
                out_stall_pct = pick_pct();
            end
            if (i >= RANDOM_ITEMS - CALM_TAIL)
            begin
                in_gap_pct    = 0;
                out_stall_pct = 0;
            end
            if (i == FILL_AT)
            begin
                for (int s = 0; s < NUM_SLOTS; s++)
                begin
                    t          = random_fields();
                    t.slot     = SLOT_W'(s);
                    t.start_kb = '0;
                    t.end_kb   = KB_W'(4095);
                    t.present  = 1'b1;
                    issue(t, 1'b0, none);
                end
                repeat (16)
                begin
                    t       = random_lookup();
                    t.query = ADDR_W'($urandom_range(0, COMPACT_TOP));
                    issue(t, 1'b0, none);
                end
                for (int s = 0; s < NUM_SLOTS; s++)
                    issue(random_load(SLOT_W'(s)), 1'b0, none);
            end
            if ($urandom_range(0, 99) < 40)
                t = random_load(SLOT_W'($urandom_range(0, NUM_SLOTS - 1)));
            else
                t = random_lookup();
            issue(t, 1'b0, none);
        end
        in_valid <= 1'b0;

        while (pending_hits.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d table loads and %0d lookups, %0d of which hit a present device.",
                 n_loads, n_lookups, n_hits);
        $display("Largest number of overlapping matches seen in one lookup: %0d.", max_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
